// ----- src/ihex_pkg.sv -----
// shared types, constants and the hex digit decoder for the hex record parser
// no dependencies; imported by every module of the block

package ihex_pkg;

  // characters with a meaning in the record grammar
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // record types that are acted on
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EXT  = 8'h04;

  // digits per field
  localparam logic [2:0] BYTE_DIGITS = 3'd2;
  localparam logic [2:0] WORD_DIGITS = 3'd4;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam int ADDR_W = 17;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_WAIT   = 8'b0000_0001,
    PH_COUNT  = 8'b0000_0010,
    PH_ADDR   = 8'b0000_0100,
    PH_TYPE   = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_OFFSET = 8'b0010_0000,
    PH_SKIP   = 8'b0100_0000,
    PH_HALT   = 8'b1000_0000
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
  } result_t;

  // ascii hex digit to value, anything else decodes as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      case (c) inside
        [8'h30:8'h39]: v = c - 8'h30;
        [8'h41:8'h46]: v = c - 8'h37;
        [8'h61:8'h66]: v = c - 8'h57;
        default:       v = 8'h00;
      endcase
      hex_value = v[3:0];
    end
  endfunction

endpackage

// ----- src/intel_hex_record_parser_unit.sv -----
// top level of the hex record parser: input register, parser step, result register
// depends on ihex_pkg, ihex_in_reg, ihex_step, ihex_out_reg

// Parses hex record text one character per transaction and emits one memory
// write per data byte of a type 0 record (address = record address + byte
// index) while the extended offset latched by type 4 is zero. A line that
// does not start with a colon gives one error result and halts the parser
// until reset. A character is registered on entry, the parser state updates
// when the registered character moves on, and any result is held in an
// output register, so a new character is accepted every cycle as long as the
// result consumer keeps up. A result becomes visible after the character has
// passed the input register and the result register has taken the result.

module intel_hex_record_parser_unit
  import ihex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  logic [7:0]        char_in,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              kind,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_data
);

  logic       item_valid;
  logic       item_take;
  logic [7:0] item_char;
  logic       space;
  logic       emit;
  result_t    result;

  // a character moves on when the result register has room
  assign item_take = item_valid && space;

  ihex_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_in    (char_in),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_char  (item_char)
  );

  ihex_step u_step (
    .clk    (clk),
    .rst    (rst),
    .take   (item_take),
    .c      (item_char),
    .emit   (emit),
    .result (result)
  );

  ihex_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .space         (space),
    .load          (emit),
    .result        (result),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .write_address (write_address),
    .write_data    (write_data)
  );

endmodule

// ----- src/ihex_in_reg.sv -----
// input register: captures one character transaction per cycle while it is empty or its held character moves on
// depends on ihex_pkg (style only)

module ihex_in_reg
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_in,
  output logic       item_valid,
  input  logic       item_take,
  output logic [7:0] item_char
);

  logic       held;
  logic [7:0] char_q;

  // accept when empty or when the held item leaves this cycle
  assign char_ready = !held || item_take;
  assign item_valid = held;
  assign item_char  = char_q;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (char_ready) begin
      held <= char_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      char_q <= char_in;
    end
  end

endmodule

// ----- src/ihex_step.sv -----
// record parser state and the per-character update logic
// depends on ihex_pkg for phases, constants, result_t and hex_value

module ihex_step
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] c,
  output logic       emit,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] field_accum, field_accum_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [15:0] extended_offset, extended_offset_next;

  logic [15:0] accum_shift;
  logic [2:0]  digit_inc;
  logic        byte_done;
  logic        word_done;
  logic [7:0]  index_inc;

  // digit shift and field completion
  assign accum_shift = {field_accum[11:0], hex_value(c)};
  assign digit_inc   = digit_count + 3'd1;
  assign byte_done   = digit_inc >= BYTE_DIGITS;
  assign word_done   = digit_inc >= WORD_DIGITS;
  assign index_inc   = byte_index + 8'd1;

  // next state and result
  always_comb begin
    phase_next           = phase;
    digit_count_next     = digit_count;
    field_accum_next     = field_accum;
    byte_count_next      = byte_count;
    record_address_next  = record_address;
    byte_index_next      = byte_index;
    extended_offset_next = extended_offset;
    emit                 = 1'b0;
    result.kind          = KIND_WRITE;
    result.write_address = {1'b0, record_address} + {9'd0, byte_index};
    result.write_data    = accum_shift[7:0];
    if (take) begin
      case (phase)
        PH_HALT: begin
        end
        PH_WAIT: begin
          if (c != CH_COLON) begin
            phase_next           = PH_HALT;
            emit                 = 1'b1;
            result.kind          = KIND_ERROR;
            result.write_address = '0;
            result.write_data    = '0;
          end else begin
            phase_next       = PH_COUNT;
            digit_count_next = '0;
            field_accum_next = '0;
          end
        end
        default: begin
          if (c == CH_NEWLINE) begin
            // newline ends the record wherever it falls
            phase_next       = PH_WAIT;
            digit_count_next = '0;
            field_accum_next = '0;
          end else begin
            digit_count_next = digit_inc;
            field_accum_next = accum_shift;
            case (phase)
              PH_COUNT: begin
                if (byte_done) begin
                  byte_count_next  = accum_shift[7:0];
                  phase_next       = PH_ADDR;
                  digit_count_next = '0;
                  field_accum_next = '0;
                end
              end
              PH_ADDR: begin
                if (word_done) begin
                  record_address_next = accum_shift;
                  phase_next          = PH_TYPE;
                  digit_count_next    = '0;
                  field_accum_next    = '0;
                end
              end
              PH_TYPE: begin
                if (byte_done) begin
                  byte_index_next  = '0;
                  digit_count_next = '0;
                  field_accum_next = '0;
                  if (accum_shift[7:0] == TYPE_DATA && extended_offset == 16'd0
                      && byte_count != 8'd0) begin
                    phase_next = PH_DATA;
                  end else if (accum_shift[7:0] == TYPE_EXT) begin
                    phase_next = PH_OFFSET;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
              end
              PH_DATA: begin
                if (byte_done) begin
                  emit             = 1'b1;
                  byte_index_next  = index_inc;
                  digit_count_next = '0;
                  field_accum_next = '0;
                  if (index_inc >= byte_count) begin
                    phase_next = PH_SKIP;
                  end
                end
              end
              PH_OFFSET: begin
                if (word_done) begin
                  extended_offset_next = accum_shift;
                  phase_next           = PH_SKIP;
                  digit_count_next     = '0;
                  field_accum_next     = '0;
                end
              end
              default: begin
                // skip phase: hold everything until newline
                digit_count_next = digit_count;
                field_accum_next = field_accum;
              end
            endcase
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      digit_count     <= '0;
      field_accum     <= '0;
      byte_count      <= '0;
      record_address  <= '0;
      byte_index      <= '0;
      extended_offset <= '0;
    end else begin
      phase           <= phase_next;
      digit_count     <= digit_count_next;
      field_accum     <= field_accum_next;
      byte_count      <= byte_count_next;
      record_address  <= record_address_next;
      byte_index      <= byte_index_next;
      extended_offset <= extended_offset_next;
    end
  end

  // halted parser stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left halt without reset");

  // an error result only comes from a line start
  a_error_source: assert property (@(posedge clk) disable iff (rst)
    emit && result.kind == KIND_ERROR |-> phase == PH_WAIT)
    else $error("error result outside line start");

  // data writes only in the data phase with a zero offset
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    emit && result.kind == KIND_WRITE |-> phase == PH_DATA && extended_offset == 16'd0)
    else $error("write outside a data record");

  // a field never holds more than a word of digits
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digit_count < WORD_DIGITS)
    else $error("digit count out of range");

endmodule

// ----- src/ihex_out_reg.sv -----
// result register: holds one result transaction until the consumer takes it
// depends on ihex_pkg for result_t

module ihex_out_reg
  import ihex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  output logic              space,
  input  logic              load,
  input  result_t           result,
  output logic              result_valid,
  input  logic              result_ready,
  output logic              kind,
  output logic [ADDR_W-1:0] write_address,
  output logic [7:0]        write_data
);

  result_t held;

  // room when empty or draining this cycle
  assign space         = !result_valid || result_ready;
  assign kind          = held.kind;
  assign write_address = held.write_address;
  assign write_data    = held.write_data;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= result;
    end
  end

endmodule
